@@ sv/cddn_pkg.sv @@
// shared types, constants and calendar helpers for the date / day number converter
package cddn_pkg;

  localparam logic [1:0]  OpNorm      = 2'd0;
  localparam logic [1:0]  OpToDate    = 2'd1;
  localparam logic [1:0]  OpAdd       = 2'd2;

  localparam logic [11:0] FirstYear   = 12'd1900;
  localparam logic [15:0] FirstYearIn = 16'd1900;
  localparam logic [15:0] LastYearIn  = 16'd2099;
  localparam logic [7:0]  LastOff     = 8'd199;
  localparam logic [7:0]  FallbackOff = 8'd100;
  localparam logic [16:0] MaxNumber   = 17'd73049;
  localparam logic [8:0]  YearShort   = 9'd365;
  localparam logic [8:0]  YearLong    = 9'd366;
  localparam logic [3:0]  LastMonth   = 4'd12;

  typedef struct packed {
    logic load_in;
    logic calc_base;
    logic calc_num;
    logic year_step;
    logic month_step;
    logic load_out;
  } cddn_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } cddn_stat_t;

  // year given as offset from 1900; 1900 itself is not leap, 2000 is
  function automatic logic is_leap(input logic [7:0] k);
    return (k[1:0] == 2'd0) && (k != 8'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [7:0] k, input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd2:                     len = is_leap(k) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/cddn_ctrl.sv @@
// sequencer for the date / day number converter
module cddn_ctrl
  import cddn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  cddn_stat_t stat,
  output cddn_cmd_t cmd
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StNorm   = 3'd1;
  localparam logic [2:0] StClamp  = 3'd2;
  localparam logic [2:0] StYears  = 3'd3;
  localparam logic [2:0] StMonths = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid, out_valid_next;

  assign s_tready = (state == StIdle);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      StIdle: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = StNorm;
        end
      end
      StNorm: begin
        cmd.calc_base = 1'b1;
        state_next    = StClamp;
      end
      StClamp: begin
        cmd.calc_num = 1'b1;
        state_next   = StYears;
      end
      StYears: begin
        if (stat.year_more) cmd.year_step = 1'b1;
        else state_next = StMonths;
      end
      StMonths: begin
        if (stat.month_more) cmd.month_step = 1'b1;
        else state_next = StFinish;
      end
      StFinish: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("result loaded but not offered");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && m_tvalid && !m_tready))
    else $error("pending result overwritten");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> cmd.calc_base)
    else $error("accepted request not processed");
`endif

endmodule

@@ sv/cddn_dpath.sv @@
// datapath: request capture, normalization, clamping, year and month walk, result register
module cddn_dpath
  import cddn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  cddn_cmd_t   cmd,
  output cddn_stat_t  stat,
  output logic [39:0] m_tdata
);

  logic [1:0]  op;
  logic [15:0] year_in;
  logic [7:0]  month_in;
  logic [7:0]  day_in;
  logic [17:0] num_in;
  logic [17:0] delta;

  logic [16:0] base;
  logic [16:0] num;
  logic [16:0] rest;
  logic [7:0]  yy;
  logic [3:0]  mm;

  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [16:0] out_num;

  // normalization
  logic        year_ok, month_ok, day_ok;
  logic [7:0]  k;
  logic [3:0]  m_n;
  logic [4:0]  dim, d_n;
  logic [16:0] year_days, leaps_before, feb_extra, base_calc;

  assign year_ok  = (year_in >= FirstYearIn) && (year_in <= LastYearIn);
  assign k        = year_ok ? 8'(year_in - FirstYearIn) : FallbackOff;
  assign month_ok = (month_in >= 8'd1) && (month_in <= 8'd12);
  assign m_n      = month_ok ? month_in[3:0] : 4'd1;
  assign dim      = month_len(k, m_n);
  assign day_ok   = (day_in != 8'd0) && (day_in <= {3'b000, dim});
  assign d_n      = day_ok ? day_in[4:0] : 5'd1;

  assign year_days    = 17'(k) * 17'(YearShort);
  assign leaps_before = (k == 8'd0) ? 17'd0 : 17'((k - 8'd1) >> 2);
  assign feb_extra    = ((m_n > 4'd2) && is_leap(k)) ? 17'd1 : 17'd0;
  assign base_calc    = 17'(d_n) + 17'(cum_days(m_n)) + feb_extra + year_days + leaps_before;

  // op select and clamp
  logic signed [18:0] sum;
  logic [16:0]        clamped;

  always_comb begin
    case (op)
      OpToDate: sum = $signed({num_in[17], num_in});
      OpAdd:    sum = $signed({2'b00, base}) + $signed({delta[17], delta});
      default:  sum = $signed({2'b00, base});
    endcase
    if (sum < $signed(19'sd1)) clamped = 17'd1;
    else if (sum > $signed({2'b00, MaxNumber})) clamped = MaxNumber;
    else clamped = sum[16:0];
  end

  // one year or one month per step
  logic [8:0] year_len;
  logic [4:0] mon_len;

  assign year_len        = is_leap(yy) ? YearLong : YearShort;
  assign mon_len         = month_len(yy, mm);
  assign stat.year_more  = (yy < LastOff) && (rest >= 17'(year_len));
  assign stat.month_more = (mm < LastMonth) && (rest >= 17'(mon_len));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op       <= s_tuser;
      year_in  <= s_tdata[15:0];
      month_in <= s_tdata[23:16];
      day_in   <= s_tdata[31:24];
      num_in   <= s_tdata[49:32];
      delta    <= s_tdata[67:50];
    end
    if (cmd.calc_base) base <= base_calc;
    if (cmd.calc_num) begin
      num  <= clamped;
      rest <= clamped - 17'd1;
      yy   <= 8'd0;
      mm   <= 4'd1;
    end
    if (cmd.year_step) begin
      rest <= rest - 17'(year_len);
      yy   <= yy + 8'd1;
    end
    if (cmd.month_step) begin
      rest <= rest - 17'(mon_len);
      mm   <= mm + 4'd1;
    end
    if (cmd.load_out) begin
      out_year  <= FirstYear + 12'(yy);
      out_month <= mm;
      out_day   <= rest[4:0] + 5'd1;
      out_num   <= num;
    end
  end

  assign m_tdata = {2'b00, out_num, out_day, out_month, out_year};

`ifndef SYNTHESIS
  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.year_step |=> (yy <= LastOff))
    else $error("year walk past last year");
  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.month_step |=> (mm >= 4'd1 && mm <= LastMonth))
    else $error("month walk out of range");
  a_month_rest: assert property (@(posedge clk) disable iff (rst)
    cmd.month_step |-> (rest < 17'(YearLong)))
    else $error("month walk with more than a year left");
`endif

endmodule

@@ sv/calendar_date_day_number_unit.sv @@
// top level of the gregorian date / day number converter
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | request: tuser op, tdata year, month, day, number, delta
//  m_*      | out       | result: tdata year, month, day, day number
//
// a request is captured, normalized and clamped, then walks one whole year per step
// (0..199 years) and then one whole month per step (0..11 months) on the shared
// rest register before its result is loaded into the result register and offered
// one request is in work at a time; s_tready is high only while the sequencer idles
// the result register lets the next request start while a result waits on m_tready
// rst is synchronous and active high; it clears the sequencer and the result valid
module calendar_date_day_number_unit
  import cddn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year[15:0], month[23:16], day[31:24], day_number_in[49:32], delta[67:50], zero pad
  input  logic [71:0] s_tdata,
  // op[1:0]: 0 normalize, 1 number to date, 2 date plus delta, 3 as 0
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // year_out[11:0], month_out[15:12], day_out[20:16], day_number_out[37:21], zero pad
  output logic [39:0] m_tdata
);

  cddn_cmd_t  cmd;
  cddn_stat_t stat;

  // sequencer: handshakes and step commands
  cddn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: normalize, clamp, walk years then months
  cddn_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata)
  );

endmodule
